### hw/rtl/twwe_pkg.sv
package twwe_pkg;

    localparam int TEXT_DEPTH_DEF = 64;
    localparam int GLYPH_DEPTH    = 256;

    localparam logic [7:0] CH_NL  = 8'd10;
    localparam logic [7:0] CH_SP  = 8'd32;
    localparam logic [7:0] CH_TAB = 8'd9;

    localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

    localparam logic [2:0] CFG_X_SCALE     = 3'd0;
    localparam logic [2:0] CFG_Y_SCALE     = 3'd1;
    localparam logic [2:0] CFG_SPACE_WIDTH = 3'd2;
    localparam logic [2:0] CFG_LINE_HEIGHT = 3'd3;
    localparam logic [2:0] CFG_WRAP_WIDTH  = 3'd4;

    localparam logic [1:0] MODE_GLYPH = 2'd0;
    localparam logic [1:0] MODE_TEXT  = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic KIND_EXTENTS = 1'b0;
    localparam logic KIND_CHAR    = 1'b1;

    typedef enum logic [1:0] {
        TA_I,
        TA_BP,
        TA_IDX
    } t_taddr;

    typedef struct packed {
        logic   accept;
        t_taddr taddr;
        logic   nl_wr;
        logic   nl_at_bp;
        logic   calc_prod;
        logic   wrap_init;
        logic   meas_init;
        logic   inc_i;
        logic   i_from_bp;
        logic   bp_from_i;
        logic   dec_bp;
        logic   width_clr;
        logic   width_add;
        logic   lines_inc;
        logic   best_upd;
        logic   ht1;
        logic   ht2;
        logic   out_ext;
        logic   out_rb;
    } t_cmd;

    typedef struct packed {
        logic       i_end;
        logic       bp_zero;
        logic       q_nl;
        logic       q_brk;
        logic       over;
        logic [1:0] in_mode;
        logic       in_last;
        logic       in_makes_result;
        logic       out_busy;
    } t_status;

endpackage

### hw/rtl/twwe_ram.sv
module twwe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

### hw/rtl/twwe_ctrl.sv
module twwe_ctrl import twwe_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_stall,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RB,
        S_WRD,
        S_WCH,
        S_WGL,
        S_WADD,
        S_BRD,
        S_BCH,
        S_MRD,
        S_MCH,
        S_MGL,
        S_MADD,
        S_MFIN,
        S_H2,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.taddr = TA_I;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = i_status.out_busy && i_status.in_makes_result;
                if (i_in_valid && !o_in_stall) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.in_mode == MODE_READ) begin
                        o_cmd.taddr = TA_IDX;
                        n_state = S_RB;
                    end else if (i_status.in_mode == MODE_TEXT && i_status.in_last) begin
                        o_cmd.wrap_init = 1'b1;
                        n_state = S_WRD;
                    end
                end
            end
            S_RB: begin
                o_cmd.out_rb = 1'b1;
                n_state = S_IDLE;
            end
            S_WRD: begin
                if (i_status.i_end) begin
                    o_cmd.meas_init = 1'b1;
                    n_state = S_MRD;
                end else begin
                    n_state = S_WCH;
                end
            end
            S_WCH: begin
                if (i_status.q_nl) begin
                    o_cmd.width_clr = 1'b1;
                    o_cmd.lines_inc = 1'b1;
                    o_cmd.inc_i     = 1'b1;
                    n_state = S_WRD;
                end else begin
                    n_state = S_WGL;
                end
            end
            S_WGL: begin
                o_cmd.calc_prod = 1'b1;
                n_state = S_WADD;
            end
            S_WADD: begin
                o_cmd.width_add = 1'b1;
                if (i_status.over) begin
                    o_cmd.bp_from_i = 1'b1;
                    n_state = S_BRD;
                end else begin
                    o_cmd.inc_i = 1'b1;
                    n_state = S_WRD;
                end
            end
            S_BRD: begin
                o_cmd.taddr = TA_BP;
                if (i_status.bp_zero) begin
                    o_cmd.nl_wr     = 1'b1;
                    o_cmd.width_clr = 1'b1;
                    o_cmd.lines_inc = 1'b1;
                    o_cmd.inc_i     = 1'b1;
                    n_state = S_WRD;
                end else begin
                    n_state = S_BCH;
                end
            end
            S_BCH: begin
                o_cmd.taddr = TA_BP;
                if (i_status.q_nl) begin
                    o_cmd.nl_wr     = 1'b1;
                    o_cmd.width_clr = 1'b1;
                    o_cmd.lines_inc = 1'b1;
                    o_cmd.inc_i     = 1'b1;
                    n_state = S_WRD;
                end else if (i_status.q_brk) begin
                    o_cmd.nl_wr     = 1'b1;
                    o_cmd.nl_at_bp  = 1'b1;
                    o_cmd.width_clr = 1'b1;
                    o_cmd.lines_inc = 1'b1;
                    o_cmd.i_from_bp = 1'b1;
                    n_state = S_WRD;
                end else begin
                    o_cmd.dec_bp = 1'b1;
                    n_state = S_BRD;
                end
            end
            S_MRD: begin
                n_state = i_status.i_end ? S_MFIN : S_MCH;
            end
            S_MCH: begin
                if (i_status.q_nl) begin
                    o_cmd.best_upd  = 1'b1;
                    o_cmd.width_clr = 1'b1;
                    o_cmd.inc_i     = 1'b1;
                    n_state = S_MRD;
                end else begin
                    n_state = S_MGL;
                end
            end
            S_MGL: begin
                o_cmd.calc_prod = 1'b1;
                n_state = S_MADD;
            end
            S_MADD: begin
                o_cmd.width_add = 1'b1;
                o_cmd.inc_i     = 1'b1;
                n_state = S_MRD;
            end
            S_MFIN: begin
                o_cmd.best_upd = 1'b1;
                o_cmd.ht1      = 1'b1;
                n_state = S_H2;
            end
            S_H2: begin
                o_cmd.ht2 = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                o_cmd.out_ext = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/twwe_dp.sv
module twwe_dp import twwe_pkg::*; #(
    parameter int TEXT_DEPTH = TEXT_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_code,
    input  logic [15:0] i_glyph_width,
    input  logic        i_glyph_present,
    input  logic        i_last,
    input  logic [5:0]  i_index,
    input  logic        i_out_stall,
    output logic        o_out_valid,
    output logic        o_result_kind,
    output logic [7:0]  o_char_out,
    output logic [6:0]  o_line_count,
    output logic [31:0] o_max_width,
    output logic [31:0] o_total_height,
    output logic        o_overflow
);

    localparam int AW = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
    localparam int LW = $clog2(TEXT_DEPTH + 1);
    localparam int NW = $clog2(TEXT_DEPTH + 2);
    localparam int CW = (LW > 6) ? LW : 6;
    localparam int HW = NW + 24;
    localparam int GAW = $clog2(GLYPH_DEPTH);

    logic [15:0] r_x_scale;
    logic [15:0] r_y_scale;
    logic [7:0]  r_space_width;
    logic [7:0]  r_line_height;
    logic [31:0] r_wrap_width;

    logic [GLYPH_DEPTH-1:0] r_gvalid;
    logic [LW-1:0] r_len;
    logic          r_ovf;
    logic          r_closed;
    logic [LW-1:0] r_i;
    logic [AW-1:0] r_bp;
    logic [31:0]   r_width;
    logic [31:0]   r_best;
    logic [NW-1:0] r_lines;
    logic [7:0]    r_char;
    logic [31:0]   r_prod;
    logic [5:0]    r_idx;
    logic [NW+7:0] r_lh;
    logic [HW-1:0] r_ht;
    logic          r_out_valid;

    logic [LW-1:0] len_eff;
    logic          load_text;
    logic          t_we;
    logic [AW-1:0] t_waddr;
    logic [7:0]    t_wdata;
    logic [AW-1:0] t_raddr;
    logic [7:0]    t_q;
    logic          g_we;
    logic [15:0]   g_q;
    logic [32:0]   sum;
    logic [31:0]   sat_sum;
    logic [32:0]   glyph_prod;
    logic [CW-1:0] idx_w;

    assign len_eff   = r_closed ? '0 : r_len;
    assign load_text = i_cmd.accept && i_mode == MODE_TEXT && i_code != 8'd0
                       && len_eff < LW'(TEXT_DEPTH);
    assign g_we      = i_cmd.accept && i_mode == MODE_GLYPH;

    always_comb begin
        if (load_text) begin
            t_we    = 1'b1;
            t_waddr = AW'(len_eff);
            t_wdata = i_code;
        end else begin
            t_we    = i_cmd.nl_wr;
            t_waddr = i_cmd.nl_at_bp ? r_bp : AW'(r_i);
            t_wdata = CH_NL;
        end
        unique case (i_cmd.taddr)
            TA_I:    t_raddr = AW'(r_i);
            TA_BP:   t_raddr = r_bp;
            TA_IDX:  t_raddr = AW'(i_index);
            default: t_raddr = AW'(r_i);
        endcase
    end

    twwe_ram #(.WIDTH(8), .DEPTH(TEXT_DEPTH)) u_text (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (t_waddr),
        .i_wdata (t_wdata),
        .i_raddr (t_raddr),
        .o_rdata (t_q)
    );

    twwe_ram #(.WIDTH(16), .DEPTH(GLYPH_DEPTH)) u_glyph (
        .i_clk   (i_clk),
        .i_we    (g_we),
        .i_waddr (GAW'(i_code)),
        .i_wdata (i_glyph_width),
        .i_raddr (GAW'(t_q)),
        .o_rdata (g_q)
    );

    assign sum        = {1'b0, r_width} + {1'b0, r_prod};
    assign sat_sum    = sum[32] ? SAT32 : sum[31:0];
    assign glyph_prod = ({16'd0, g_q} + 33'd1) * {17'd0, r_x_scale};
    assign idx_w      = CW'(r_idx);

    assign o_status.i_end           = (r_i == r_len);
    assign o_status.bp_zero         = (r_bp == '0);
    assign o_status.q_nl            = (t_q == CH_NL);
    assign o_status.q_brk           = (t_q == CH_SP) || (t_q == CH_TAB);
    assign o_status.over            = (r_wrap_width != 32'd0) && (sat_sum > r_wrap_width);
    assign o_status.in_mode         = i_mode;
    assign o_status.in_last         = i_last;
    assign o_status.in_makes_result = (i_mode == MODE_READ) || (i_mode == MODE_TEXT && i_last);
    assign o_status.out_busy        = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_scale     <= 16'd256;
            r_y_scale     <= 16'd256;
            r_space_width <= 8'd0;
            r_line_height <= 8'd0;
            r_wrap_width  <= 32'd0;
            r_gvalid      <= '0;
            r_len         <= '0;
            r_ovf         <= 1'b0;
            r_closed      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_X_SCALE:     r_x_scale     <= i_cfg_data[15:0];
                    CFG_Y_SCALE:     r_y_scale     <= i_cfg_data[15:0];
                    CFG_SPACE_WIDTH: r_space_width <= i_cfg_data[7:0];
                    CFG_LINE_HEIGHT: r_line_height <= i_cfg_data[7:0];
                    CFG_WRAP_WIDTH:  r_wrap_width  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (g_we) begin
                r_gvalid[i_code] <= i_glyph_present;
            end
            if (i_cmd.accept && i_mode == MODE_TEXT) begin
                if (load_text) begin
                    r_len <= len_eff + LW'(1);
                end else begin
                    r_len <= len_eff;
                end
                if (i_code != 8'd0 && !load_text) begin
                    r_ovf <= 1'b1;
                end else if (r_closed) begin
                    r_ovf <= 1'b0;
                end
                r_closed <= i_last;
            end
            if (i_cmd.out_ext || i_cmd.out_rb) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_char <= t_q;
        if (i_cmd.accept) begin
            r_idx <= i_index;
        end
        if (i_cmd.wrap_init || i_cmd.meas_init) begin
            r_i     <= '0;
            r_width <= 32'd0;
        end else begin
            if (i_cmd.inc_i) begin
                r_i <= r_i + LW'(1);
            end else if (i_cmd.i_from_bp) begin
                r_i <= LW'(r_bp) + LW'(1);
            end
            if (i_cmd.width_clr) begin
                r_width <= 32'd0;
            end else if (i_cmd.width_add) begin
                r_width <= sat_sum;
            end
        end
        if (i_cmd.wrap_init) begin
            r_lines <= NW'(1);
        end else if (i_cmd.lines_inc) begin
            r_lines <= r_lines + NW'(1);
        end
        if (i_cmd.meas_init) begin
            r_best <= 32'd0;
        end else if (i_cmd.best_upd && r_width > r_best) begin
            r_best <= r_width;
        end
        if (i_cmd.bp_from_i) begin
            r_bp <= AW'(r_i);
        end else if (i_cmd.dec_bp) begin
            r_bp <= r_bp - AW'(1);
        end
        if (i_cmd.calc_prod) begin
            if (r_gvalid[r_char]) begin
                r_prod <= glyph_prod[31:0];
            end else begin
                r_prod <= {8'd0, r_space_width} * {16'd0, r_x_scale};
            end
        end
        if (i_cmd.ht1) begin
            r_lh <= (NW+8)'(r_lines) * (NW+8)'(r_line_height);
        end
        if (i_cmd.ht2) begin
            r_ht <= HW'(r_lh) * HW'(r_y_scale);
        end
        if (i_cmd.out_ext) begin
            o_result_kind  <= KIND_EXTENTS;
            o_char_out     <= 8'd0;
            o_line_count   <= (r_lines > NW'(127)) ? 7'd127 : 7'(r_lines);
            o_max_width    <= r_best;
            o_total_height <= (r_ht > HW'(SAT32)) ? SAT32 : 32'(r_ht);
            o_overflow     <= r_ovf;
        end else if (i_cmd.out_rb) begin
            o_result_kind  <= KIND_CHAR;
            o_char_out     <= (idx_w < CW'(r_len) && idx_w < CW'(TEXT_DEPTH)) ? t_q : 8'd0;
            o_line_count   <= 7'd0;
            o_max_width    <= 32'd0;
            o_total_height <= 32'd0;
            o_overflow     <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

### hw/rtl/text_word_wrap_extents_top.sv
// Greedy word wrap and text extents.
// Input channel (i_in_valid / o_in_stall) carries glyph writes, text characters and
// read-back requests; the output channel (o_out_valid / i_out_stall) returns one
// extents result per completed string and one character per read-back.
// Glyph writes and text characters without last are taken back to back, and are taken
// even while a result waits on the output.
// A read-back passes through the registered text memory read and the output register.
// After the last character the block wraps and then measures the string, one
// character at a time through the text memory read port: in each pass a character
// steps through text read, glyph read, multiply and add, a newline through text read
// and check only, and every step of the back search for a break through a read and
// a check. The height arithmetic follows both passes; no input is taken meanwhile.
// A request that makes a result waits while an earlier result is still on the output.
// Reset returns the configuration registers to their defaults, the glyph table to all absent and
// the string to empty; glyph widths and text memory are not cleared.
module text_word_wrap_extents_top import twwe_pkg::*; #(
    parameter int TEXT_DEPTH = TEXT_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_code,
    input  logic [15:0] i_glyph_width,
    input  logic        i_glyph_present,
    input  logic        i_last,
    input  logic [5:0]  i_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_result_kind,
    output logic [7:0]  o_char_out,
    output logic [6:0]  o_line_count,
    output logic [31:0] o_max_width,
    output logic [31:0] o_total_height,
    output logic        o_overflow
);

    t_cmd    cmd;
    t_status status;

    twwe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    twwe_dp #(.TEXT_DEPTH(TEXT_DEPTH)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_mode          (i_mode),
        .i_code          (i_code),
        .i_glyph_width   (i_glyph_width),
        .i_glyph_present (i_glyph_present),
        .i_last          (i_last),
        .i_index         (i_index),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_result_kind   (o_result_kind),
        .o_char_out      (o_char_out),
        .o_line_count    (o_line_count),
        .o_max_width     (o_max_width),
        .o_total_height  (o_total_height),
        .o_overflow      (o_overflow)
    );

    a_read_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_mode == MODE_READ) |-> ##2 o_out_valid)
        else $error("read-back result missing");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.out_ext || cmd.out_rb) |-> !status.out_busy)
        else $error("pending result overwritten");

    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_mode == MODE_TEXT && i_last) |=> o_in_stall)
        else $error("input taken during wrap");

endmodule

### bench/twwe_checker.sv
module twwe_checker import twwe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_code,
    input  logic [15:0] i_glyph_width,
    input  logic        i_glyph_present,
    input  logic        i_last,
    input  logic [5:0]  i_index,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_result_kind,
    input  logic [7:0]  i_char_out,
    input  logic [6:0]  i_line_count,
    input  logic [31:0] i_max_width,
    input  logic [31:0] i_total_height,
    input  logic        i_overflow,
    output int          o_fails,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = TEXT_DEPTH_DEF;

    typedef struct packed {
        logic        kind;
        logic [7:0]  ch;
        logic [6:0]  lines;
        logic [31:0] widest;
        logic [31:0] height;
        logic        ovf;
    } t_result;

    t_result     want_q[$];
    logic [15:0] x_scale, y_scale;
    logic [7:0]  space_w, line_h;
    logic [31:0] wrap_w;
    logic        glyph_on [GLYPH_DEPTH];
    logic [15:0] glyph_w [GLYPH_DEPTH];
    logic [7:0]  text_mem [DEPTH];
    int          text_len;
    logic        ovf_flag, closed;

    initial o_fails = 0;
    assign o_pending = want_q.size();

    function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? SAT32 : s[31:0];
    endfunction

    function automatic logic [31:0] char_extent(logic [7:0] c);
        if (glyph_on[c])
            return ({16'd0, glyph_w[c]} + 32'd1) * {16'd0, x_scale};
        return {24'd0, space_w} * {16'd0, x_scale};
    endfunction

    function automatic int wrap_string();
        int          lines, i, bp;
        logic [31:0] run;
        logic        hit;
        lines = 1;
        run = '0;
        i = 0;
        while (i < text_len) begin
            if (text_mem[i] == CH_NL) begin
                run = '0;
                lines++;
            end else begin
                run = sat_sum(run, char_extent(text_mem[i]));
                if (wrap_w != 0 && run > wrap_w) begin
                    bp = i;
                    hit = 1'b0;
                    while (bp > 0 && text_mem[bp] != CH_NL) begin
                        if (text_mem[bp] == CH_SP || text_mem[bp] == CH_TAB) begin
                            hit = 1'b1;
                            break;
                        end
                        bp--;
                    end
                    if (hit) begin
                        text_mem[bp] = CH_NL;
                        i = bp;
                    end else begin
                        text_mem[i] = CH_NL;
                    end
                    run = '0;
                    lines++;
                end
            end
            i++;
        end
        return lines;
    endfunction

    function automatic logic [31:0] widest_line();
        logic [31:0] best, cur;
        best = '0;
        cur = '0;
        for (int i = 0; i < text_len; i++) begin
            if (text_mem[i] == CH_NL) begin
                if (cur > best) best = cur;
                cur = '0;
            end else begin
                cur = sat_sum(cur, char_extent(text_mem[i]));
            end
        end
        if (cur > best) best = cur;
        return best;
    endfunction

    task automatic predict_item();
        t_result          r;
        int               lines;
        longint unsigned  h;
        r = '0;
        if (i_mode == MODE_GLYPH) begin
            glyph_on[i_code] = i_glyph_present;
            glyph_w[i_code] = i_glyph_width;
        end else if (i_mode == MODE_TEXT) begin
            if (closed) begin
                text_len = 0;
                ovf_flag = 1'b0;
                closed = 1'b0;
            end
            if (i_code != 0) begin
                if (text_len < DEPTH) begin
                    text_mem[text_len] = i_code;
                    text_len++;
                end else begin
                    ovf_flag = 1'b1;
                end
            end
            if (i_last) begin
                closed = 1'b1;
                lines = wrap_string();
                h = longint'(lines) * longint'(line_h) * longint'(y_scale);
                r.kind = KIND_EXTENTS;
                r.lines = (lines > 127) ? 7'd127 : lines[6:0];
                r.widest = widest_line();
                r.height = (h > 64'hFFFF_FFFF) ? SAT32 : h[31:0];
                r.ovf = ovf_flag;
                want_q.push_back(r);
            end
        end else if (i_mode == MODE_READ) begin
            r.kind = KIND_CHAR;
            r.ch = (i_index < text_len) ? text_mem[i_index] : 8'd0;
            want_q.push_back(r);
        end
    endtask

    task automatic check_result();
        t_result w;
        if (want_q.size() == 0) begin
            $display("%0t: result with nothing expected, kind %0d", $time, i_result_kind);
            o_fails++;
            return;
        end
        w = want_q.pop_front();
        if (i_result_kind !== w.kind) begin
            $display("%0t: kind expected %0d got %0d", $time, w.kind, i_result_kind);
            o_fails++;
        end
        if (i_char_out !== w.ch) begin
            $display("%0t: char expected %0d got %0d", $time, w.ch, i_char_out);
            o_fails++;
        end
        if (i_line_count !== w.lines) begin
            $display("%0t: lines expected %0d got %0d", $time, w.lines, i_line_count);
            o_fails++;
        end
        if (i_max_width !== w.widest) begin
            $display("%0t: width expected %0h got %0h", $time, w.widest, i_max_width);
            o_fails++;
        end
        if (i_total_height !== w.height) begin
            $display("%0t: height expected %0h got %0h", $time, w.height, i_total_height);
            o_fails++;
        end
        if (i_overflow !== w.ovf) begin
            $display("%0t: overflow expected %0d got %0d", $time, w.ovf, i_overflow);
            o_fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            x_scale = 16'd256;
            y_scale = 16'd256;
            space_w = '0;
            line_h = '0;
            wrap_w = '0;
            for (int k = 0; k < GLYPH_DEPTH; k++) glyph_on[k] = 1'b0;
            text_len = 0;
            ovf_flag = 1'b0;
            closed = 1'b0;
            want_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) check_result();
            if (i_in_valid && !i_in_stall) predict_item();
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_X_SCALE:     x_scale = i_cfg_data[15:0];
                    CFG_Y_SCALE:     y_scale = i_cfg_data[15:0];
                    CFG_SPACE_WIDTH: space_w = i_cfg_data[7:0];
                    CFG_LINE_HEIGHT: line_h = i_cfg_data[7:0];
                    CFG_WRAP_WIDTH:  wrap_w = i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

### bench/tb_top.sv
module tb_top import twwe_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 500000;
    localparam int MODE_NONE = 3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic [1:0]  i_mode = '0;
    logic [7:0]  i_code = '0;
    logic [15:0] i_glyph_width = '0;
    logic        i_glyph_present = 1'b0;
    logic        i_last = 1'b0;
    logic [5:0]  i_index = '0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall, o_out_valid, o_result_kind, o_overflow;
    logic [7:0]  o_char_out;
    logic [6:0]  o_line_count;
    logic [31:0] o_max_width, o_total_height;
    int          fails, pending;
    int          items_sent = 0, strings_sent = 0, reads_sent = 0;
    int          hold_request = 0;
    int          idle_cycles = 0;
    logic        steady = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    text_word_wrap_extents_top u_top (.*);

    twwe_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data, .i_in_valid,
        .i_in_stall(o_in_stall), .i_mode, .i_code, .i_glyph_width, .i_glyph_present,
        .i_last, .i_index, .i_out_valid(o_out_valid), .i_out_stall,
        .i_result_kind(o_result_kind), .i_char_out(o_char_out),
        .i_line_count(o_line_count), .i_max_width(o_max_width),
        .i_total_height(o_total_height), .i_overflow(o_overflow),
        .o_fails(fails), .o_pending(pending)
    );

    // The receiver draws a wait after every transfer, and obeys a long hold when asked.
    always begin
        int wait_left;
        wait_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                i_out_stall <= 1'b1;
                hold_request--;
            end else if (o_out_valid && !i_out_stall) begin
                wait_left = steady ? 0 : $urandom_range(0, 10);
                i_out_stall <= (wait_left != 0);
                if (wait_left != 0) wait_left--;
            end else if (wait_left > 0) begin
                i_out_stall <= 1'b1;
                wait_left--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send(input logic [1:0] m, input logic [7:0] c, input logic [15:0] gw,
                        input logic gp, input logic lst, input logic [5:0] idx);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode <= m;
        i_code <= c;
        i_glyph_width <= gw;
        i_glyph_present <= gp;
        i_last <= lst;
        i_index <= idx;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
        if (m == MODE_TEXT && lst) strings_sent++;
        if (m == MODE_READ) reads_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_regs(input logic [15:0] xs, input logic [15:0] ys,
                            input logic [7:0] sw, input logic [7:0] lh, input logic [31:0] ww);
        write_reg(CFG_X_SCALE, {16'd0, xs});
        write_reg(CFG_Y_SCALE, {16'd0, ys});
        write_reg(CFG_SPACE_WIDTH, {24'd0, sw});
        write_reg(CFG_LINE_HEIGHT, {24'd0, lh});
        write_reg(CFG_WRAP_WIDTH, ww);
    endtask

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return CH_SP;
        if (r < 20) return CH_TAB;
        if (r < 24) return CH_NL;
        if (r < 26) return 8'd0;
        if (r < 36) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(8'h61, 8'h6A));
    endfunction

    task automatic send_string(input int len);
        for (int k = 0; k < len; k++)
            send(MODE_TEXT, pick_char(), 16'($urandom), 1'($urandom), 1'b0, 6'($urandom));
        send(MODE_TEXT, ($urandom_range(0, 9) == 0) ? 8'd0 : pick_char(), 16'($urandom),
             1'($urandom), 1'b1, 6'($urandom));
    endtask

    task automatic send_glyph();
        logic [15:0] gw;
        logic [7:0]  c;
        c = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(8'h61, 8'h6A));
        case ($urandom_range(0, 9))
            0:       gw = 16'hFFFF;
            1:       gw = 16'($urandom);
            default: gw = 16'($urandom_range(0, 15));
        endcase
        send(MODE_GLYPH, c, gw, $urandom_range(0, 7) != 0, 1'($urandom), 6'($urandom));
    endtask

    initial begin
        logic [15:0] xs;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: table extremes, empty, short and overflowing strings, read-back edges, mode three.
        set_regs(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 32'd1);
        send(MODE_GLYPH, 8'd0, 16'hFFFF, 1'b1, 1'b0, '0);
        send(MODE_GLYPH, 8'hFF, 16'd0, 1'b1, 1'b1, 6'h3F);
        send(MODE_GLYPH, 8'h61, 16'd3, 1'b1, 1'b0, '0);
        send(MODE_READ, '0, '0, 1'b0, 1'b0, 6'd0);
        send(MODE_TEXT, 8'd0, '0, 1'b0, 1'b1, '0);
        send(MODE_TEXT, 8'h61, '0, 1'b0, 1'b0, '0);
        send(MODE_TEXT, CH_SP, '0, 1'b0, 1'b0, '0);
        send(MODE_TEXT, 8'hFF, '0, 1'b0, 1'b0, '0);
        send(MODE_TEXT, CH_TAB, '0, 1'b0, 1'b0, '0);
        send(MODE_TEXT, 8'h62, '0, 1'b0, 1'b1, '0);
        send(MODE_READ, '0, '0, 1'b0, 1'b0, 6'd1);
        send(MODE_READ, '0, '0, 1'b0, 1'b0, 6'd63);
        send(2'(MODE_NONE), 8'hFF, 16'hFFFF, 1'b1, 1'b1, 6'h3F);
        send(MODE_GLYPH, 8'hFF, 16'd0, 1'b0, 1'b0, '0);
        drain();
        set_regs(16'd256, 16'd256, 8'd2, 8'd12, 32'd2048);
        send_string(70);
        send(MODE_READ, '0, '0, 1'b0, 1'b0, 6'd63);
        send(MODE_TEXT, 8'h61, '0, 1'b0, 1'b1, '0);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            steady = (phase == 3);
            case (phase)
                0: set_regs(16'd0, 16'd0, 8'd0, 8'd0, 32'd0);
                1: set_regs(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
                default: begin
                    xs = ($urandom_range(0, 1) != 0) ? 16'd256 : 16'($urandom);
                    set_regs(xs, 16'($urandom), 8'($urandom), 8'($urandom),
                             (phase % 3 == 0) ? 32'd0 : $urandom_range(1, 60) * xs);
                end
            endcase
            if (phase == 2) hold_request = 400;
            for (int n = 0; n < 24; n++) send_glyph();
            while (items_sent < 230 * (phase + 1)) begin
                case ($urandom_range(0, 19))
                    0, 1:    send_glyph();
                    2, 3, 4: send(MODE_READ, '0, 16'($urandom), 1'($urandom), 1'($urandom),
                                  6'($urandom));
                    5:       send(2'(MODE_NONE), 8'($urandom), 16'($urandom), 1'($urandom),
                                  1'($urandom), 6'($urandom));
                    6:       send_string($urandom_range(55, 75));
                    default: send_string($urandom_range(0, 18));
                endcase
            end
            drain();
        end
        steady = 1'b0;

        repeat (20) @(posedge i_clk);
        $display("Sent %0d items: %0d strings wrapped and measured, %0d read-backs,",
                 items_sent, strings_sent, reads_sent);
        $display("over ten register settings including all-zero and all-max scales.");
        if (fails == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/twwe_pkg.sv
hw/rtl/twwe_ram.sv
hw/rtl/twwe_ctrl.sv
hw/rtl/twwe_dp.sv
hw/rtl/text_word_wrap_extents_top.sv
bench/twwe_checker.sv
bench/tb_top.sv
